// File: rtl/core/jfss_pkg.sv
// Shared types and constants of the JPEG frame size scanner.
// No dependencies; used by every module under rtl/core.
package jfss_pkg;

    // Configuration register file
    localparam int LEN_BITS      = 20;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;
    localparam logic [REG_IDX_BITS-1:0] REG_STREAM_LENGTH = 1'b0;

    // Marker bytes
    localparam logic [7:0] MARK_BYTE = 8'hFF;
    localparam logic [7:0] SOI_BYTE  = 8'hD8;

    // Stream length limits and scan window
    localparam int MIN_LEN_SOI  = 4;
    localparam int MIN_LEN_SCAN = 12;
    localparam int SCAN_TAIL    = 9;
    localparam int SCAN_START   = 2;
    localparam int SEG_HDR      = 2;
    localparam int SEG_MIN_STEP = 4;

    // Offsets from the marker byte inside a frame header
    localparam int SOF_HEIGHT_HI = 5;
    localparam int SOF_HEIGHT_LO = 6;
    localparam int SOF_WIDTH_HI  = 7;
    localparam int SOF_WIDTH_LO  = 8;
    localparam int SEG_LEN_LO    = 3;

    typedef enum logic [2:0] {
        PH_SOI0    = 3'd0,
        PH_SOI1    = 3'd1,
        PH_SEEK    = 3'd2,
        PH_MARKER  = 3'd3,
        PH_SEGLEN  = 3'd4,
        PH_SOFBODY = 3'd5,
        PH_DONE    = 3'd6
    } phase_t;

    typedef struct packed {
        logic        found;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } res_t;

    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } buf_stat_t;

    // Start-of-frame markers: C0-C3, C5-C7, C9-CB
    function automatic logic is_frame_marker(input logic [7:0] m);
        logic hit;
        begin
            hit = ((m >= 8'hC0) && (m <= 8'hC3)) ||
                  ((m >= 8'hC5) && (m <= 8'hC7)) ||
                  ((m >= 8'hC9) && (m <= 8'hCB));
            return hit;
        end
    endfunction

endpackage

// File: rtl/core/jfss_cfg.sv
// APB register file holding the stream length.
// Depends on jfss_pkg.
module jfss_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [jfss_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [jfss_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [jfss_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output logic [jfss_pkg::LEN_BITS-1:0]        stream_length
);

    logic [jfss_pkg::LEN_BITS-1:0]     len_reg;
    logic [jfss_pkg::LEN_BITS-1:0]     len_next;
    logic [jfss_pkg::REG_IDX_BITS-1:0] reg_idx;
    logic                              wr_len;

    assign reg_idx = paddr[jfss_pkg::APB_ADDR_BITS-1:2];
    assign wr_len  = psel && penable && pwrite && (reg_idx == jfss_pkg::REG_STREAM_LENGTH);
    assign pready  = 1'b1;

    // Take the low bits of the written word
    always_comb
    begin
        len_next = len_reg;
        if (wr_len)
        begin
            len_next = pwdata[jfss_pkg::LEN_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // Read back; unmapped addresses read as zero
    always_comb
    begin
        prdata = '0;
        if (reg_idx == jfss_pkg::REG_STREAM_LENGTH)
        begin
            prdata = {{(jfss_pkg::APB_DATA_BITS - jfss_pkg::LEN_BITS){1'b0}}, len_reg};
        end
    end

    assign stream_length = len_reg;

endmodule

// File: rtl/core/jfss_parse.sv
// Per-byte marker parser: scan state registers and the decision logic of one byte.
// Depends on jfss_pkg.
module jfss_parse
#(
    parameter int POSITION_BITS = 20
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [7:0]                    data_byte,
    input  logic                          last,
    input  logic [jfss_pkg::LEN_BITS-1:0] stream_length,
    output logic                          res_valid,
    output jfss_pkg::res_t                res,
    output jfss_pkg::phase_t              phase
);

    // Compare width: covers position plus a full 16-bit segment length and the stream length
    localparam int WIDE = ((POSITION_BITS > jfss_pkg::LEN_BITS) ? POSITION_BITS
                                                                 : jfss_pkg::LEN_BITS) + 2;

    jfss_pkg::phase_t          phase_reg;
    jfss_pkg::phase_t          phase_next;
    logic [POSITION_BITS-1:0]  pos_reg;
    logic [POSITION_BITS-1:0]  pos_next;
    logic [POSITION_BITS-1:0]  scan_reg;
    logic [POSITION_BITS-1:0]  scan_next;
    logic [7:0]                hist_reg;
    logic [7:0]                hist_next;
    logic [15:0]               height_reg;
    logic [15:0]               height_next;

    logic [WIDE-1:0]           len_w;
    logic [WIDE-1:0]           scan_w;
    logic [WIDE-1:0]           seek_nj;
    logic [WIDE-1:0]           seg_sum;
    logic [WIDE-1:0]           seg_min;
    logic [WIDE-1:0]           seg_nj;
    logic [POSITION_BITS-1:0]  offs;
    logic                      at_scan;
    logic                      is_ff;
    logic                      seg_first;
    logic                      give_nf;
    logic                      give_f;
    logic                      give;

    // Scan arithmetic
    assign len_w     = WIDE'(stream_length);
    assign scan_w    = WIDE'(scan_reg);
    assign seek_nj   = scan_w + WIDE'(1);
    assign seg_sum   = scan_w + WIDE'(jfss_pkg::SEG_HDR) + WIDE'({hist_reg, data_byte});
    assign seg_min   = scan_w + WIDE'(jfss_pkg::SEG_MIN_STEP);
    assign seg_nj    = (seg_sum < seg_min) ? seg_min : seg_sum;
    assign offs      = pos_reg - scan_reg;
    assign at_scan   = (pos_reg == scan_reg);
    assign is_ff     = (data_byte == jfss_pkg::MARK_BYTE);
    assign seg_first = (offs < POSITION_BITS'(jfss_pkg::SEG_LEN_LO));

    // Decide whether this byte ends the file's search
    always_comb
    begin
        give_nf = 1'b0;
        give_f  = 1'b0;
        unique case (phase_reg)
            jfss_pkg::PH_SOI0:
            begin
                give_nf = (len_w < WIDE'(jfss_pkg::MIN_LEN_SOI)) || !is_ff;
            end
            jfss_pkg::PH_SOI1:
            begin
                give_nf = (data_byte != jfss_pkg::SOI_BYTE) ||
                          (len_w < WIDE'(jfss_pkg::MIN_LEN_SCAN));
            end
            jfss_pkg::PH_SEEK:
            begin
                give_nf = at_scan && !is_ff &&
                          ((seek_nj + WIDE'(jfss_pkg::SCAN_TAIL)) >= len_w);
            end
            jfss_pkg::PH_SEGLEN:
            begin
                give_nf = !seg_first &&
                          ((seg_nj + WIDE'(jfss_pkg::SCAN_TAIL)) >= len_w);
            end
            jfss_pkg::PH_SOFBODY:
            begin
                give_f = (offs == POSITION_BITS'(jfss_pkg::SOF_WIDTH_LO));
            end
            default:
            begin
            end
        endcase
    end

    assign give = give_nf || give_f;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            if (last)
            begin
                phase_next = jfss_pkg::PH_SOI0;
            end
            else if (give)
            begin
                phase_next = jfss_pkg::PH_DONE;
            end
            else
            begin
                unique case (phase_reg)
                    jfss_pkg::PH_SOI0:    phase_next = jfss_pkg::PH_SOI1;
                    jfss_pkg::PH_SOI1:    phase_next = jfss_pkg::PH_SEEK;
                    jfss_pkg::PH_SEEK:
                    begin
                        if (at_scan && is_ff)
                        begin
                            phase_next = jfss_pkg::PH_MARKER;
                        end
                    end
                    jfss_pkg::PH_MARKER:
                    begin
                        phase_next = jfss_pkg::is_frame_marker(data_byte) ?
                                     jfss_pkg::PH_SOFBODY : jfss_pkg::PH_SEGLEN;
                    end
                    jfss_pkg::PH_SEGLEN:
                    begin
                        if (!seg_first)
                        begin
                            phase_next = jfss_pkg::PH_SEEK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Position, scan pointer and held header bytes
    always_comb
    begin
        pos_next    = pos_reg;
        scan_next   = scan_reg;
        hist_next   = hist_reg;
        height_next = height_reg;
        if (step)
        begin
            if (last)
            begin
                pos_next    = '0;
                scan_next   = POSITION_BITS'(jfss_pkg::SCAN_START);
                hist_next   = '0;
                height_next = '0;
            end
            else
            begin
                // Saturate on an overlong file
                if (pos_reg != '1)
                begin
                    pos_next = pos_reg + POSITION_BITS'(1);
                end
                if (!give)
                begin
                    unique case (phase_reg)
                        jfss_pkg::PH_SOI1:
                        begin
                            scan_next = POSITION_BITS'(jfss_pkg::SCAN_START);
                        end
                        jfss_pkg::PH_SEEK:
                        begin
                            if (at_scan && !is_ff)
                            begin
                                scan_next = seek_nj[POSITION_BITS-1:0];
                            end
                        end
                        jfss_pkg::PH_SEGLEN:
                        begin
                            if (seg_first)
                            begin
                                hist_next = data_byte;
                            end
                            else
                            begin
                                scan_next = seg_nj[POSITION_BITS-1:0];
                            end
                        end
                        jfss_pkg::PH_SOFBODY:
                        begin
                            if (offs == POSITION_BITS'(jfss_pkg::SOF_HEIGHT_HI))
                            begin
                                height_next = {data_byte, 8'h00};
                            end
                            else if (offs == POSITION_BITS'(jfss_pkg::SOF_HEIGHT_LO))
                            begin
                                height_next = {height_reg[15:8], data_byte};
                            end
                            else if (offs == POSITION_BITS'(jfss_pkg::SOF_WIDTH_HI))
                            begin
                                hist_next = data_byte;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= jfss_pkg::PH_SOI0;
            pos_reg    <= '0;
            scan_reg   <= POSITION_BITS'(jfss_pkg::SCAN_START);
            hist_reg   <= '0;
            height_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            scan_reg   <= scan_next;
            hist_reg   <= hist_next;
            height_reg <= height_next;
        end
    end

    // One result per file: at the deciding byte, else at the last byte
    assign res_valid        = step && (phase_reg != jfss_pkg::PH_DONE) && (give || last);
    assign res.found        = give_f;
    assign res.image_width  = give_f ? {hist_reg, data_byte} : 16'h0000;
    assign res.image_height = give_f ? height_reg : 16'h0000;
    assign phase            = phase_reg;

endmodule

// File: rtl/core/jfss_out_buf.sv
// Two-word result buffer: output register plus skid stage.
// Depends on jfss_pkg.
module jfss_out_buf
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jfss_pkg::res_t      push_data,
    output logic                can_push,
    output logic                out_valid,
    input  logic                out_ready,
    output jfss_pkg::res_t      out_data,
    output jfss_pkg::buf_stat_t stat
);

    logic           main_valid_reg;
    logic           main_valid_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    jfss_pkg::res_t main_reg;
    jfss_pkg::res_t main_next;
    jfss_pkg::res_t skid_reg;
    jfss_pkg::res_t skid_next;
    logic           pop;

    assign pop      = main_valid_reg && out_ready;
    assign can_push = !skid_valid_reg;

    // Advance the skid word, drop a new word into the free slot, or empty the output on a pop
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload holds carry no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid       = main_valid_reg;
    assign out_data        = main_reg;
    assign stat.main_valid = main_valid_reg;
    assign stat.skid_valid = skid_valid_reg;

endmodule

// File: rtl/core/jpeg_frame_size_scanner_core.sv
// Top level of the JPEG frame size scanner: APB registers, marker parser, result buffer.
// Depends on jfss_pkg, jfss_cfg, jfss_parse and jfss_out_buf.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   input    | in_valid/in_ready   | data_byte[7:0], last
//   output   | out_valid/out_ready | found, image_width[15:0], image_height[15:0]
//   config   | psel/penable/pready | paddr[2:0], pwdata/prdata[31:0]
//
// One byte is taken every cycle while in_ready is high; the parser decides each byte in
// the cycle it is taken. A result is registered into the output register, or into the
// skid word while the output register holds a result not yet taken. The two-word result
// buffer lets input run on while one result waits; in_ready drops only when both words
// are full. Reset clears the scan state and the stream length; no clearing pass follows.
module jpeg_frame_size_scanner_core
#(
    parameter int POSITION_BITS = 20
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          data_byte,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic [15:0]                         image_width,
    output logic [15:0]                         image_height,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [jfss_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [jfss_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [jfss_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    logic [jfss_pkg::LEN_BITS-1:0] stream_length;
    logic                          step;
    logic                          res_valid;
    jfss_pkg::res_t                res;
    jfss_pkg::res_t                out_data;
    jfss_pkg::phase_t              phase;
    jfss_pkg::buf_stat_t           buf_stat;

    jfss_cfg u_cfg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .stream_length (stream_length)
    );

    assign step = in_valid && in_ready;

    jfss_parse #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parse
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (data_byte),
        .last          (last),
        .stream_length (stream_length),
        .res_valid     (res_valid),
        .res           (res),
        .phase         (phase)
    );

    jfss_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .stat      (buf_stat)
    );

    assign found        = out_data.found;
    assign image_width  = out_data.image_width;
    assign image_height = out_data.image_height;

`ifndef SYNTHESIS
    // The skid word is only ever filled behind a full output register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        buf_stat.skid_valid |-> buf_stat.main_valid)
        else $error("skid word held with empty output register");

    // A last byte rearms the parser
    a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last) |=> (phase == jfss_pkg::PH_SOI0))
        else $error("parser not rearmed after last byte");

    // A file still undecided at its last byte yields a result there
    a_last_gives: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last && (phase != jfss_pkg::PH_DONE)) |-> res_valid)
        else $error("no result for a file at its last byte");

    // No second result once the file is decided
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (phase == jfss_pkg::PH_DONE) |-> !res_valid)
        else $error("second result for one file");

    // Not-found results carry zero sizes
    a_zero_sizes: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.found) |-> ((res.image_width == 16'h0000) &&
                                      (res.image_height == 16'h0000)))
        else $error("not-found result with non-zero size");
`endif

endmodule
